// File: hdl/pcmrms_pkg.sv
// pcmrms_pkg: widths and constants of the rms level meter
// no dependencies; used by the top level by scoped names
`timescale 1ns / 1ps

package pcmrms_pkg;

   // sample and result widths
   localparam int SAMPLE_W    = 16;
   localparam int MAG_W       = 17;
   localparam int LEVEL_W     = 17;
   localparam int RSP_TDATA_W = 24;

   // log2 mantissa format, q1.30
   localparam int MANT_BITS = 30;
   localparam int MANT_W    = 31;

   // shared multiplier
   localparam int MUL_W  = 31;
   localparam int PROD_W = 62;
   localparam int TRUNC_W = 32;

   // 10*log10(2) in q16 and the -160 db floor in q8.8
   localparam logic [MUL_W-1:0]   TEN_LOG10_2_Q16 = 31'd197283;
   localparam logic [LEVEL_W-1:0] FLOOR_Q88       = 17'd40960;

endpackage

// File: hdl/pcmrms_norm.sv
// pcmrms_norm: iterative leading-one normalizer, one binary search step a cycle
// no dependencies; used by pcm_rms_level_meter_db_top
`timescale 1ns / 1ps

module pcmrms_norm #(
   parameter int VAL_W = 43
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic [VAL_W-1:0]           value,
   output logic                       busy,
   output logic [VAL_W-1:0]           norm_val,
   output logic [$clog2(VAL_W)-1:0]   shift_cnt
);

   localparam int SHC_W  = $clog2(VAL_W);
   localparam int NSH    = SHC_W;
   localparam int STEP_W = $clog2(NSH);

   logic [VAL_W-1:0]  val_ff, val_in;
   logic [SHC_W-1:0]  shc_ff, shc_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic [SHC_W-1:0]  sh_amt;
   logic [VAL_W-1:0]  hi_mask;

   // shift by the current power of two when the top bits are all zero
   always_comb begin
      sh_amt  = SHC_W'(1) << step_ff;
      hi_mask = ~({VAL_W{1'b1}} >> sh_amt);
      val_in  = val_ff;
      shc_in  = shc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (load) begin
         val_in  = value;
         shc_in  = '0;
         step_in = STEP_W'(NSH - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if ((val_ff & hi_mask) == '0) begin
            val_in = val_ff << sh_amt;
            shc_in = shc_ff + sh_amt;
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff - STEP_W'(1);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      shc_ff  <= shc_in;
      step_ff <= step_in;
   end

   assign busy      = busy_ff;
   assign norm_val  = val_ff;
   assign shift_cnt = shc_ff;

endmodule

// File: hdl/pcm_rms_level_meter_db_top.sv
// pcm_rms_level_meter_db_top: frame rms level in dbfs from 16-bit pcm samples
// depends on pcmrms_pkg and pcmrms_norm
`timescale 1ns / 1ps
//
// channel   direction  tdata                          tlast / tuser
// req_*     in         [15:0] sample                  tlast = frame_end
// rsp_*     out        [16:0] level_db (q8.8), zeros  none
//
// a sample without frame end passes through accept, square and accumulate.
// a frame end sample then goes on through the one shared 31x31 multiplier that
// squares the log2 mantissa once per fraction bit, for the sum and then the count.
// reset clears the sum, the count and the result valid flag; a stalled result
// holds the block only when the next frame end is ready to be delivered.

module pcm_rms_level_meter_db_top #(
   parameter int MAX_FRAME     = 4096,
   parameter int LOG_FRAC_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pcmrms_pkg::SAMPLE_W-1:0]     req_tdata,   // [15:0] sample
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pcmrms_pkg::RSP_TDATA_W-1:0]  rsp_tdata    // [16:0] level_db, [23:17] zero
);

   localparam int CNT_W  = $clog2(MAX_FRAME + 1);
   localparam int SUM_W  = pcmrms_pkg::MANT_BITS + CNT_W;
   localparam int PW     = $clog2(SUM_W);
   localparam int LOG_W  = PW + LOG_FRAC_BITS;
   localparam int ITER_W = $clog2(LOG_FRAC_BITS);
   localparam logic [LOG_W-1:0] LOG_OFFSET =
      LOG_W'(pcmrms_pkg::MANT_BITS * (2 ** LOG_FRAC_BITS));
   localparam logic [pcmrms_pkg::PROD_W-1:0] RND_HALF =
      pcmrms_pkg::PROD_W'(1) << (LOG_FRAC_BITS + 7);

   // sequencer codes
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SQ    = 4'd1;
   localparam logic [3:0] ST_ACC   = 4'd2;
   localparam logic [3:0] ST_LOAD  = 4'd3;
   localparam logic [3:0] ST_NORM  = 4'd4;
   localparam logic [3:0] ST_MANT  = 4'd5;
   localparam logic [3:0] ST_SQR   = 4'd6;
   localparam logic [3:0] ST_FIX   = 4'd7;
   localparam logic [3:0] ST_LOGD  = 4'd8;
   localparam logic [3:0] ST_SCALE = 4'd9;
   localparam logic [3:0] ST_RND   = 4'd10;
   localparam logic [3:0] ST_OUT   = 4'd11;

   logic [3:0]                           state_ff, state_in;
   logic [SUM_W-1:0]                     sum_ff, sum_in;
   logic [CNT_W-1:0]                     cnt_ff, cnt_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [pcmrms_pkg::LEVEL_W-1:0]       rsp_data_ff, rsp_data_in;
   logic [pcmrms_pkg::MAG_W-1:0]         abs_ff, abs_in;
   logic                                 last_ff, last_in;
   logic                                 counted_ff, counted_in;
   logic                                 phase_ff, phase_in;
   logic [pcmrms_pkg::MANT_W-1:0]        mant_ff, mant_in;
   logic [PW-1:0]                        p_ff, p_in;
   logic [LOG_FRAC_BITS-1:0]             frac_ff, frac_in;
   logic [ITER_W-1:0]                    iter_ff, iter_in;
   logic [LOG_W-1:0]                     ls_ff, ls_in;
   logic [LOG_W-1:0]                     diff_ff, diff_in;
   logic [pcmrms_pkg::LEVEL_W-1:0]       mag_ff, mag_in;
   logic [pcmrms_pkg::PROD_W-1:0]        prod_ff, prod_in;
   logic [pcmrms_pkg::MUL_W-1:0]         mul_a, mul_b;

   logic                                 norm_load;
   logic [SUM_W-1:0]                     norm_value;
   logic                                 norm_busy;
   logic [SUM_W-1:0]                     norm_val;
   logic [PW-1:0]                        norm_shc;

   logic signed [pcmrms_pkg::MAG_W-1:0]  sample_ext;
   logic [pcmrms_pkg::TRUNC_W-1:0]       sq_trunc;
   logic [LOG_W-1:0]                     log_now;
   logic [LOG_W-1:0]                     sub_val;
   logic [pcmrms_pkg::PROD_W-1:0]        rnd_val;

   // leading-one search for both logarithms
   pcmrms_norm #(
      .VAL_W (SUM_W)
   ) u_norm (
      .clock     (clock),
      .reset     (reset),
      .load      (norm_load),
      .value     (norm_value),
      .busy      (norm_busy),
      .norm_val  (norm_val),
      .shift_cnt (norm_shc)
   );

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         ST_SQ: begin
            mul_a = pcmrms_pkg::MUL_W'(abs_ff);
            mul_b = pcmrms_pkg::MUL_W'(abs_ff);
         end
         ST_SQR: begin
            mul_a = mant_ff;
            mul_b = mant_ff;
         end
         ST_SCALE: begin
            mul_a = pcmrms_pkg::MUL_W'(diff_ff);
            mul_b = pcmrms_pkg::TEN_LOG10_2_Q16;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = pcmrms_pkg::PROD_W'(mul_a) * pcmrms_pkg::PROD_W'(mul_b);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      abs_in       = abs_ff;
      last_in      = last_ff;
      counted_in   = counted_ff;
      phase_in     = phase_ff;
      mant_in      = mant_ff;
      p_in         = p_ff;
      frac_in      = frac_ff;
      iter_in      = iter_ff;
      ls_in        = ls_ff;
      diff_in      = diff_ff;
      mag_in       = mag_ff;
      norm_load    = 1'b0;
      norm_value   = sum_ff;

      sample_ext = $signed({req_tdata[pcmrms_pkg::SAMPLE_W-1], req_tdata});
      sq_trunc   = prod_ff[pcmrms_pkg::MANT_BITS +: pcmrms_pkg::TRUNC_W];
      log_now    = {p_ff, frac_ff};
      sub_val    = log_now + LOG_OFFSET;
      rnd_val    = (prod_ff + RND_HALF) >> (LOG_FRAC_BITS + 8);

      // result register drains independently
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               abs_in     = (sample_ext < 0) ? pcmrms_pkg::MAG_W'(-sample_ext)
                                             : pcmrms_pkg::MAG_W'(sample_ext);
               last_in    = req_tlast;
               counted_in = (cnt_ff < CNT_W'(MAX_FRAME));
               state_in   = ST_SQ;
            end
         end
         ST_SQ: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (counted_ff) begin
               sum_in = sum_ff + SUM_W'(prod_ff[pcmrms_pkg::TRUNC_W-1:0]);
               cnt_in = cnt_ff + CNT_W'(1);
            end
            state_in = last_ff ? ST_LOAD : ST_IDLE;
         end
         ST_LOAD: begin
            // silent frame goes straight to the floor
            if (sum_ff == '0) begin
               mag_in   = pcmrms_pkg::FLOOR_Q88;
               state_in = ST_OUT;
            end else begin
               norm_load  = 1'b1;
               norm_value = sum_ff;
               phase_in   = 1'b0;
               state_in   = ST_NORM;
            end
         end
         ST_NORM: begin
            if (!norm_busy) begin
               state_in = ST_MANT;
            end
         end
         ST_MANT: begin
            mant_in  = norm_val[SUM_W-1 -: pcmrms_pkg::MANT_W];
            p_in     = PW'(SUM_W - 1) - norm_shc;
            frac_in  = '0;
            iter_in  = '0;
            state_in = ST_SQR;
         end
         ST_SQR: begin
            state_in = ST_FIX;
         end
         ST_FIX: begin
            // one fraction bit per squaring
            frac_in = {frac_ff[LOG_FRAC_BITS-2:0], sq_trunc[pcmrms_pkg::TRUNC_W-1]};
            mant_in = sq_trunc[pcmrms_pkg::TRUNC_W-1] ?
                      sq_trunc[pcmrms_pkg::TRUNC_W-1:1] :
                      sq_trunc[pcmrms_pkg::MANT_W-1:0];
            if (iter_ff == ITER_W'(LOG_FRAC_BITS - 1)) begin
               state_in = ST_LOGD;
            end else begin
               iter_in  = iter_ff + ITER_W'(1);
               state_in = ST_SQR;
            end
         end
         ST_LOGD: begin
            if (!phase_ff) begin
               // sum log done, start on the count
               ls_in      = log_now;
               norm_load  = 1'b1;
               norm_value = SUM_W'(cnt_ff);
               phase_in   = 1'b1;
               state_in   = ST_NORM;
            end else if (ls_ff >= sub_val) begin
               mag_in   = '0;
               state_in = ST_OUT;
            end else begin
               diff_in  = sub_val - ls_ff;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            state_in = ST_RND;
         end
         ST_RND: begin
            // round half up, clamp at the floor
            if (rnd_val > pcmrms_pkg::PROD_W'(pcmrms_pkg::FLOOR_Q88)) begin
               mag_in = pcmrms_pkg::FLOOR_Q88;
            end else begin
               mag_in = rnd_val[pcmrms_pkg::LEVEL_W-1:0];
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pcmrms_pkg::LEVEL_W'(0) - mag_ff;
               sum_in       = '0;
               cnt_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state and frame accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      abs_ff      <= abs_in;
      last_ff     <= last_in;
      counted_ff  <= counted_in;
      phase_ff    <= phase_in;
      mant_ff     <= mant_in;
      p_ff        <= p_in;
      frac_ff     <= frac_in;
      iter_ff     <= iter_in;
      ls_ff       <= ls_in;
      diff_ff     <= diff_in;
      mag_ff      <= mag_in;
      prod_ff     <= prod_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(pcmrms_pkg::RSP_TDATA_W - pcmrms_pkg::LEVEL_W){1'b0}}, rsp_data_ff};

endmodule

// File: dv/pcm_rms_level_checker.sv
// pcm_rms_level_checker: predicts the frame level in dbfs and compares results
// watches both stream channels of pcm_rms_level_meter_db_top; no other dependencies
`timescale 1ns / 1ps

module pcm_rms_level_checker #(
   parameter int MAX_FRAME     = 4096,
   parameter int LOG_FRAC_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,     // [15:0] sample
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,     // [16:0] level_db, [23:17] zero
   output int          error_count,
   output int          pending_levels
);

   localparam int SUM_W     = 43;
   localparam int CNT_W     = $clog2(MAX_FRAME + 1);
   localparam int LEVEL_W   = 17;
   localparam int MANT_BITS = 30;
   localparam int MANT_W    = MANT_BITS + 1;
   localparam int LOG_W     = 6 + LOG_FRAC_BITS;
   localparam bit [63:0] TEN_LOG10_2_Q16 = 64'd197283;
   localparam bit [63:0] FLOOR_Q88       = 64'd40960;

   // frame accumulators and levels still owed by the block
   bit [SUM_W-1:0]   frame_energy;
   bit [CNT_W-1:0]   frame_samples;
   bit [SUM_W-1:0]   sample_mag;
   bit [LEVEL_W-1:0] expected_levels[$];
   bit [LEVEL_W-1:0] wanted_level;

   initial begin
      error_count    = 0;
      pending_levels = 0;
      frame_energy   = '0;
      frame_samples  = '0;
   end

   // log2 of a nonzero value: leading-one position, then one mantissa squaring per fraction bit
   function automatic bit [LOG_W-1:0] fixed_log2(input bit [SUM_W-1:0] x);
      int unsigned            lead;
      bit [MANT_W-1:0]        mant;
      bit [2*MANT_W-1:0]      squared;
      bit [MANT_W:0]          shifted;
      bit [LOG_FRAC_BITS-1:0] frac;
      lead = 0;
      frac = '0;
      for (int b = 0; b < SUM_W; b++) begin
         if (x[b]) lead = b;
      end
      if (lead > MANT_BITS) mant = MANT_W'(x >> (lead - MANT_BITS));
      else mant = MANT_W'(x << (MANT_BITS - lead));
      for (int i = 0; i < LOG_FRAC_BITS; i++) begin
         squared = mant * mant;
         shifted = (MANT_W + 1)'(squared >> MANT_BITS);
         frac    = (frac << 1) | LOG_FRAC_BITS'(shifted[MANT_W]);
         mant    = shifted[MANT_W] ? shifted[MANT_W:1] : shifted[MANT_W-1:0];
      end
      return (LOG_W'(lead) << LOG_FRAC_BITS) | LOG_W'(frac);
   endfunction

   // level in q8.8: -(10*log10(2) * (log2(count) + 30 - log2(sum))), clamped to [-160, 0] db
   function automatic bit [LEVEL_W-1:0] dbfs_level(input bit [SUM_W-1:0] energy,
                                                   input bit [CNT_W-1:0] samples);
      bit [63:0] log_energy;
      bit [63:0] log_bound;
      bit [63:0] diff;
      bit [63:0] mag;
      if (energy == 0 || samples == 0) begin
         mag = FLOOR_Q88;
      end else begin
         log_energy = fixed_log2(energy);
         log_bound  = fixed_log2(SUM_W'(samples)) + (64'(MANT_BITS) << LOG_FRAC_BITS);
         if (log_energy >= log_bound) begin
            // truncation can push the level above full scale
            mag = 0;
         end else begin
            diff = log_bound - log_energy;
            mag  = (diff * TEN_LOG10_2_Q16 + (64'd1 << (LOG_FRAC_BITS + 7)))
                   >> (LOG_FRAC_BITS + 8);
            if (mag > FLOOR_Q88) mag = FLOOR_Q88;
         end
      end
      return LEVEL_W'(64'd0 - mag);
   endfunction

   // compare result transactions, then fold in the accepted sample
   always @(posedge clock) begin
      if (reset) begin
         frame_energy  = '0;
         frame_samples = '0;
         expected_levels.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_levels.size() == 0) begin
               $error("level_db: expected no result, actual %0d",
                      $signed(rsp_tdata[LEVEL_W-1:0]));
               error_count++;
            end else begin
               wanted_level = expected_levels.pop_front();
               if (rsp_tdata[LEVEL_W-1:0] !== wanted_level) begin
                  $error("level_db: expected %0d, actual %0d",
                         $signed(wanted_level), $signed(rsp_tdata[LEVEL_W-1:0]));
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            // samples past a full frame are dropped, but a frame end still reports
            if (frame_samples < MAX_FRAME) begin
               sample_mag    = req_tdata[15] ? (SUM_W'(17'h10000) - SUM_W'(req_tdata))
                                             : SUM_W'(req_tdata);
               frame_energy  = frame_energy + sample_mag * sample_mag;
               frame_samples = frame_samples + 1'b1;
            end
            if (req_tlast) begin
               expected_levels = {expected_levels, dbfs_level(frame_energy, frame_samples)};
               frame_energy  = '0;
               frame_samples = '0;
            end
         end
      end
      pending_levels = expected_levels.size();
   end

endmodule

// File: dv/tb_pcm_rms_level_meter_db_top.sv
// tb_pcm_rms_level_meter_db_top: drives sample frames into the rms level meter
// depends on pcmrms_pkg, pcm_rms_level_meter_db_top and pcm_rms_level_checker
`timescale 1ns / 1ps

module tb_pcm_rms_level_meter_db_top;

   localparam int FRAME_LIMIT  = 4096;
   localparam int FRAC_BITS    = 12;
   localparam int RANDOM_ITEMS = 650;

   typedef enum int {AMP_ZERO, AMP_TINY, AMP_MID, AMP_FULL, AMP_ANY} amp_type;

   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [pcmrms_pkg::SAMPLE_W-1:0]     req_tdata  = '0;   // [15:0] sample
   logic                                req_tlast  = 1'b0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [pcmrms_pkg::RSP_TDATA_W-1:0]  rsp_tdata;         // [16:0] level_db, [23:17] zero
   int                                  error_count;
   int                                  pending_levels;
   bit                                  idle_on    = 1'b1;

   pcm_rms_level_meter_db_top #(
      .MAX_FRAME     (FRAME_LIMIT),
      .LOG_FRAC_BITS (FRAC_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   pcm_rms_level_checker #(
      .MAX_FRAME     (FRAME_LIMIT),
      .LOG_FRAC_BITS (FRAC_BITS)
   ) level_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .error_count    (error_count),
      .pending_levels (pending_levels)
   );

   // 100 mhz clock
   initial begin
      forever #5 clock = ~clock;
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_tready <= idle_on ? ($urandom_range(99) >= 36) : 1'b1;
   end

   // hard stop
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [15:0] pick_sample(input amp_type amp);
      case (amp)
         AMP_ZERO: return 16'h0000;
         AMP_TINY: return 16'(int'($urandom_range(0, 6)) - 3);
         AMP_MID:  return 16'(int'($urandom_range(0, 2047)) - 1024);
         AMP_FULL: begin
            case ($urandom_range(0, 2))
               0:       return 16'h8000;
               1:       return 16'h7FFF;
               default: return 16'h8001;
            endcase
         end
         default:  return 16'($urandom);
      endcase
   endfunction

   // one sample transaction, with random idle cycles ahead of it
   task automatic send_sample(input logic [15:0] sample, input bit frame_end);
      while (idle_on && $urandom_range(99) < 36) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      req_tlast  <= frame_end;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_repeat(input logic [15:0] sample, input int len);
      for (int i = 0; i < len; i++) send_sample(sample, i == len - 1);
   endtask

   task automatic send_frame(input int len, input amp_type amp);
      for (int i = 0; i < len; i++) send_sample(pick_sample(amp), i == len - 1);
   endtask

   // stimulus and verdict
   initial begin
      int      random_items;
      int      frame_len;
      bit      paused;
      amp_type amp;
      random_items = 0;
      paused       = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-sample frames: silence, full scale both ways, one lsb both ways
      send_repeat(16'h0000, 1);
      send_repeat(16'h8000, 1);
      send_repeat(16'h7FFF, 1);
      send_repeat(16'h0001, 1);
      send_repeat(16'hFFFF, 1);
      // full scale over an odd count, where truncation may round above 0 db
      send_repeat(16'h8000, 3);
      // silent multi-sample frame, then a multi-sample frame at one lsb
      send_repeat(16'h0000, 4);
      send_repeat(16'h0001, 7);
      // alternating bit patterns, then full scale both ways, in one frame
      send_sample(16'h5555, 1'b0);
      send_sample(16'hAAAA, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b1);

      // random frames, mostly short
      while (random_items < RANDOM_ITEMS) begin
         if (!paused && random_items >= 300) begin
            // drain every outstanding level before going on
            req_tvalid <= 1'b0;
            @(negedge clock);
            wait (pending_levels == 0);
            @(posedge clock);
            paused = 1'b1;
         end
         idle_on   = !(random_items >= 400 && random_items < 560);
         frame_len = ($urandom_range(0, 19) == 0) ? $urandom_range(64, 300)
                                                  : $urandom_range(1, 24);
         amp       = amp_type'($urandom_range(0, 4));
         send_frame(frame_len, amp);
         random_items += frame_len;
      end
      idle_on = 1'b1;
      req_tvalid <= 1'b0;

      // drain and let any stray result show up
      @(negedge clock);
      wait (pending_levels == 0);
      repeat (150) @(posedge clock);
      if (error_count == 0 && pending_levels == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
